@@ design/lbr_pkg.sv @@
package lbr_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = 32;

    // Generator step: state * LCG_MUL + LCG_ADD, modulo 2^64.
    localparam logic [HALF_W-1:0] LCG_MUL = 32'd214013;
    localparam logic [DATA_W-1:0] LCG_ADD = 64'd2531011;

    localparam logic [HALF_W-1:0] FULL_SPAN32 = 32'hffff_ffff;

    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_SEED = 1'b1;

    localparam logic [1:0] WSEL_8  = 2'd0;
    localparam logic [1:0] WSEL_16 = 2'd1;
    localparam logic [1:0] WSEL_32 = 2'd2;
    localparam logic [1:0] WSEL_64 = 2'd3;

    typedef struct packed {
        logic              func;
        logic [1:0]        width_sel;
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;
        logic [DATA_W-1:0] new_seed;
    } t_lbr_in;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] seed_now;
    } t_lbr_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic mul_lo;
        logic mul_hi;
        logic adv_sum;
        logic scale_mul;
        logic scale_sum;
        logic take_raw;
        logic take_hi;
        logic take_cand;
        logic finish;
    } t_lbr_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_seed;
        logic span_zero;
        logic span_wide;
        logic span_full;
        logic cand_ok;
        logic out_free;
    } t_lbr_sts;

    function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] sel);
        logic [DATA_W-1:0] m;
        case (sel)
            WSEL_8:  m = 64'h0000_0000_0000_00ff;
            WSEL_16: m = 64'h0000_0000_0000_ffff;
            WSEL_32: m = 64'h0000_0000_ffff_ffff;
            WSEL_64: m = 64'hffff_ffff_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

    // All ones from the highest set bit downward.
    function automatic logic [DATA_W-1:0] smear(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] s;
        s = x;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        s = s | (s >> 32);
        return s;
    endfunction

endpackage

@@ design/lbr_ctrl.sv @@
module lbr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lbr_pkg::t_lbr_sts i_sts,
    output lbr_pkg::t_lbr_cmd o_cmd
);
    import lbr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_ADV_A  = 3'd2;
    localparam logic [2:0] S_ADV_B  = 3'd3;
    localparam logic [2:0] S_ADV_C  = 3'd4;
    localparam logic [2:0] S_POST   = 3'd5;
    localparam logic [2:0] S_SCALE  = 3'd6;
    localparam logic [2:0] S_FINAL  = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_phase, n_phase;   // set once the high word of a wide try is held

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_phase      = 1'b0;
                if (i_sts.is_seed || i_sts.span_zero) begin
                    n_state = S_FINAL;
                end else begin
                    n_state = S_ADV_A;
                end
            end
            S_ADV_A: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_ADV_B;
            end
            S_ADV_B: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_ADV_C;
            end
            S_ADV_C: begin
                o_cmd.adv_sum = 1'b1;
                n_state       = S_POST;
            end
            S_POST: begin
                if (i_sts.span_wide) begin
                    if (!r_phase) begin
                        o_cmd.take_hi = 1'b1;
                        n_phase       = 1'b1;
                        n_state       = S_ADV_A;
                    end else if (i_sts.cand_ok) begin
                        o_cmd.take_cand = 1'b1;
                        n_state         = S_FINAL;
                    end else begin
                        n_phase = 1'b0;
                        n_state = S_ADV_A;
                    end
                end else if (i_sts.span_full) begin
                    o_cmd.take_raw = 1'b1;
                    n_state        = S_FINAL;
                end else begin
                    o_cmd.scale_mul = 1'b1;
                    n_state         = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale_sum = 1'b1;
                n_state         = S_FINAL;
            end
            S_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/lbr_dp.sv @@
module lbr_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbr_pkg::t_lbr_in  i_in_data,
    input  lbr_pkg::t_lbr_cmd i_cmd,
    output lbr_pkg::t_lbr_sts o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lbr_pkg::t_lbr_out o_out_data
);
    import lbr_pkg::*;

    logic [DATA_W-1:0] r_lcg;    // generator state
    logic              r_func;
    logic [DATA_W-1:0] r_m;      // width mask
    logic [DATA_W-1:0] r_lo;     // masked lower bound, zero for a seed load
    logic [DATA_W-1:0] r_span;
    logic [DATA_W-1:0] r_msk;    // bit-length mask of the span
    logic [DATA_W-1:0] r_prod;   // shared multiplier output
    logic [DATA_W-1:0] r_acc;
    logic [HALF_W-1:0] r_hi;
    logic [DATA_W-1:0] r_rv;     // offset above lower
    logic              r_out_valid;
    t_lbr_out          r_out;

    logic [DATA_W-1:0] w_m;
    logic [HALF_W-1:0] w_draw;
    logic [HALF_W-1:0] w_mul_a;
    logic [HALF_W-1:0] w_mul_b;
    logic [DATA_W-1:0] w_prod;
    logic [DATA_W-1:0] w_cand;
    logic [DATA_W-1:0] w_scaled;

    assign w_m      = width_mask(i_in_data.width_sel);
    assign w_draw   = r_lcg[DATA_W-1:HALF_W];
    assign w_cand   = {r_hi, w_draw} & r_msk;
    assign w_scaled = r_prod + {{HALF_W{1'b0}}, w_draw};

    always_comb begin
        w_mul_a = r_lcg[HALF_W-1:0];
        w_mul_b = LCG_MUL;
        if (i_cmd.mul_hi) begin
            w_mul_a = r_lcg[DATA_W-1:HALF_W];
        end else if (i_cmd.scale_mul) begin
            w_mul_a = w_draw;
            w_mul_b = r_span[HALF_W-1:0];
        end
    end

    assign w_prod = {{HALF_W{1'b0}}, w_mul_a} * {{HALF_W{1'b0}}, w_mul_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= '0;
        end else if (i_cmd.capture && i_in_data.func == FUNC_SEED) begin
            r_lcg <= i_in_data.new_seed;
        end else if (i_cmd.adv_sum) begin
            r_lcg <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_in_data.func;
            r_m    <= w_m;
            r_lo   <= (i_in_data.func == FUNC_SEED) ? '0 : (i_in_data.lower & w_m);
            r_span <= (i_in_data.upper - i_in_data.lower) & w_m;
        end
        if (i_cmd.decode) begin
            r_msk <= smear(r_span);
            r_rv  <= '0;
        end
        if (i_cmd.mul_lo || i_cmd.mul_hi || i_cmd.scale_mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul_hi) begin
            r_acc <= r_prod + LCG_ADD;
        end
        if (i_cmd.take_hi) begin
            r_hi <= w_draw;
        end
        if (i_cmd.take_raw) begin
            r_rv <= {{HALF_W{1'b0}}, w_draw};
        end
        if (i_cmd.scale_sum) begin
            r_rv <= {{HALF_W{1'b0}}, w_scaled[DATA_W-1:HALF_W]};
        end
        if (i_cmd.take_cand) begin
            r_rv <= w_cand;
        end
        if (i_cmd.finish) begin
            r_out.value    <= (r_rv + r_lo) & r_m;
            r_out.seed_now <= r_lcg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.is_seed   = r_func;
    assign o_sts.span_zero = (r_span == '0);
    assign o_sts.span_wide = |r_span[DATA_W-1:HALF_W];
    assign o_sts.span_full = (r_span == {{HALF_W{1'b0}}, FULL_SPAN32});
    assign o_sts.cand_ok   = (w_cand <= r_span);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/lcg_bounded_random.sv @@
// Bounded random number source built on a 64-bit linear congruential
// generator (state = state * 214013 + 2531011, draw = upper state word).
// Requests arrive on the input channel (i_in_valid / o_in_ready, payload
// i_in_data) and each one produces exactly one result on the output channel
// (o_out_valid / i_out_ready, payload o_out_data). A transfer happens on a
// rising edge where valid and ready are both high.
// A seed load goes from decode straight to the final step.
// A generator advance uses the single shared 32x32 multiplier twice and then
// a 64-bit add. A narrow span then scales the draw with the multiplier, a
// full 32-bit span takes the draw as is, and an empty span skips the draw.
// A 64-bit span needs two draws per try, and a rejected try draws both
// words again. One request is in flight at a time; the next transfer is
// taken when the previous one has been handed to the output register.
// Reset (synchronous, active low) clears the generator state to zero,
// returns the sequencer to idle and empties the output register.
// When the receiver stalls, the result holds in the output register while
// the next request is already processed; the sequencer waits at its last
// step only if a second result is ready before the first is taken.
module lcg_bounded_random (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lbr_pkg::t_lbr_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lbr_pkg::t_lbr_out o_out_data
);
    import lbr_pkg::*;

    t_lbr_cmd w_cmd;
    t_lbr_sts w_sts;

    // The sequencer decides which step runs; it never touches payload.
    lbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the generator state, the shared multiplier,
    // the range bookkeeping and the output register.
    lbr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
